/* rtl/core/sdlr_pkg.sv */
package sdlr_pkg;

	localparam int PHASE_FRAC_BITS = 16;
	localparam int MAX_UPSAMPLE    = 8;

	localparam int SAMPLE_W  = 16;
	localparam int STEP_W    = 22;
	localparam int PHASE_W   = PHASE_FRAC_BITS + 7;
	localparam int MIX_W     = PHASE_FRAC_BITS + 18;
	localparam int CNT_W     = (MAX_UPSAMPLE > 1) ? $clog2(MAX_UPSAMPLE) : 1;
	localparam int CFG_IDX_W = 2;
	localparam int S_DATA_W  = 2 * SAMPLE_W;
	localparam int M_DATA_W  = SAMPLE_W;

	localparam logic [STEP_W-1:0]  PHASE_STEP_RST = STEP_W'(98304);
	localparam logic [PHASE_W-1:0] PHASE_ONE      = PHASE_W'(1) << PHASE_FRAC_BITS;
	localparam logic [CNT_W-1:0]   CNT_LAST       = CNT_W'(MAX_UPSAMPLE - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_EIGHT_BIT  = 2'd1,
		REG_UNSIGNED   = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_FMT  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

endpackage

/* rtl/core/stereo_downmix_linear_resampler.sv */
// stereo downmix and linear interpolation resampler
//
// s_axis: one stereo frame per beat, averaged to mono (truncated toward zero).
// m_axis: interpolated output samples, tlast on the final sample of a frame.
// cfg: register writes (phase step, eight-bit mode, unsigned offset), always
// ready, to be used only while the block is idle.
//
// one shared 17 x 17 multiplier is stepped by a small sequencer: each output
// sample passes through a multiply state, a round/format state and an output
// state in turn; the first sample of a frame starts once the frame is accepted
// in idle. a frame with no result (first frame, or phase at or above one) is
// taken without leaving idle. at most eight samples come from one frame.
// s_axis_tready is high only while idle, so no frame is taken during work.
//
// reset clears the phase, the previous-sample flag and the registers to their
// defaults. a stall on m_axis holds the output beat and halts the sequencer.
module stereo_downmix_linear_resampler
	import sdlr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_DATA_W-1:0]  s_axis_tdata,   // left_sample, right_sample
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_DATA_W-1:0]  m_axis_tdata,   // sample_word
	output logic                 m_axis_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data
);

	state_t                     state_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [STEP_W-1:0]          step_q;
	logic                       eight_q;
	logic                       uns_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] cur_q;
	logic                       have_prev_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [MIX_W-1:0]    prod_q;
	logic [M_DATA_W-1:0]        word_q;
	logic                       last_q;

	logic signed [SAMPLE_W:0]         sum;
	logic signed [SAMPLE_W:0]         sum_adj;
	logic signed [SAMPLE_W-1:0]       mono;
	logic                             in_acc;
	logic                             phase_below;
	logic signed [SAMPLE_W:0]         diff;
	logic signed [PHASE_FRAC_BITS:0]  frac_s;
	logic signed [MIX_W-1:0]          mul;
	logic signed [MIX_W-1:0]          base;
	logic [MIX_W-1:0]                 mag;
	logic [MIX_W-1:0]                 rnd;
	logic [SAMPLE_W-1:0]              rbits;
	logic [SAMPLE_W-1:0]              smp;
	logic [M_DATA_W-1:0]              fmt_word;
	logic [PHASE_W-1:0]               next_phase;
	logic                             next_below;
	logic                             is_last;
	logic [PHASE_W-1:0]               final_phase;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = word_q;
	assign m_axis_tlast  = last_q;

	// downmix, truncating toward zero
	assign sum     = {s_axis_tdata[SAMPLE_W-1], s_axis_tdata[SAMPLE_W-1:0]}
	               + {s_axis_tdata[S_DATA_W-1], s_axis_tdata[S_DATA_W-1:SAMPLE_W]};
	assign sum_adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
	assign mono    = sum_adj[SAMPLE_W:1];

	assign phase_below = (phase_q[PHASE_W-1:PHASE_FRAC_BITS] == '0);

	// prev * one + (cur - prev) * frac
	assign diff   = {cur_q[SAMPLE_W-1], cur_q} - {prev_q[SAMPLE_W-1], prev_q};
	assign frac_s = {1'b0, phase_q[PHASE_FRAC_BITS-1:0]};
	assign mul    = diff * frac_s;
	assign base   = {{(MIX_W-SAMPLE_W){prev_q[SAMPLE_W-1]}}, prev_q} <<< PHASE_FRAC_BITS;

	// round half away from zero
	assign mag   = prod_q[MIX_W-1] ? MIX_W'(-prod_q) : MIX_W'(prod_q);
	assign rnd   = mag + (MIX_W'(1) << (PHASE_FRAC_BITS - 1));
	assign rbits = rnd[PHASE_FRAC_BITS+SAMPLE_W-1:PHASE_FRAC_BITS];
	assign smp   = prod_q[MIX_W-1] ? (SAMPLE_W'(0) - rbits) : rbits;

	always_comb begin
		if (eight_q) begin
			fmt_word = {8'h00, smp[15:8] ^ {uns_q, 7'h00}};
		end else begin
			fmt_word = smp ^ {uns_q, 15'h0000};
		end
	end

	assign next_phase  = phase_q + PHASE_W'(step_q);
	assign next_below  = (next_phase[PHASE_W-1:PHASE_FRAC_BITS] == '0);
	assign is_last     = !next_below || (cnt_q == CNT_LAST);
	assign final_phase = next_below ? '0 : (next_phase - PHASE_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= PHASE_STEP_RST;
			eight_q <= 1'b0;
			uns_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_PHASE_STEP) begin
				step_q <= cfg_data;
			end
			if (cfg_index == REG_EIGHT_BIT) begin
				eight_q <= cfg_data[0];
			end
			if (cfg_index == REG_UNSIGNED) begin
				uns_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			prev_q      <= '0;
			cur_q       <= '0;
			prod_q      <= '0;
			word_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cur_q <= mono;
						cnt_q <= '0;
						if (!have_prev_q) begin
							prev_q      <= mono;
							have_prev_q <= 1'b1;
						end else if (!phase_below) begin
							phase_q <= phase_q - PHASE_ONE;
							prev_q  <= mono;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= mul + base;
					state_q <= ST_FMT;
				end
				ST_FMT: begin
					word_q  <= fmt_word;
					last_q  <= is_last;
					phase_q <= is_last ? final_phase : next_phase;
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						if (last_q) begin
							prev_q  <= cur_q;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/sdlr_checker.sv */
module sdlr_checker
	import sdlr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_DATA_W-1:0]  m_axis_tdata,   // sample_word
	input logic                 m_axis_tlast
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// no new frame is taken while a sample is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while output pending");

	// frame continues after a non-final sample
	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
		else $error("input ready in the middle of a frame");

	// a sample always follows a compute state, never idle directly
	a_compute: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("output sample without a compute cycle");

endmodule

bind stereo_downmix_linear_resampler sdlr_checker u_sdlr_checker (.*);
